// ----- rtl/cccv_pkg.sv -----
`default_nettype none

package cccv_pkg;

  localparam int unsigned SampleWidth  = 10;
  localparam int unsigned CountWidth   = 12;
  localparam int unsigned DutyWidth    = 8;
  localparam int unsigned ModeWidth    = 2;
  localparam int unsigned CfgIdxWidth  = 3;
  localparam int unsigned CfgDataWidth = 12;

  // Register indexes of the configuration port.
  typedef enum logic [CfgIdxWidth-1:0] {
    REG_CURRENT_LOW  = 3'd0,
    REG_CURRENT_HIGH = 3'd1,
    REG_VOLTAGE_SP   = 3'd2,
    REG_DWELL_LIMIT  = 3'd3,
    REG_RECOVER_LIM  = 3'd4,
    REG_DUTY_CEILING = 3'd5
  } cfg_reg_e;

  // Charger mode, one-hot inside the block.
  typedef enum logic [2:0] {
    MODE_CC      = 3'b001,
    MODE_CV      = 3'b010,
    MODE_TRICKLE = 3'b100
  } mode_e;

  // Codes of the charge_mode result field.
  localparam logic [ModeWidth-1:0] CODE_CC      = 2'd0;
  localparam logic [ModeWidth-1:0] CODE_CV      = 2'd1;
  localparam logic [ModeWidth-1:0] CODE_TRICKLE = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [SampleWidth-1:0] RST_CURRENT_LOW  = 10'd242;
  localparam logic [SampleWidth-1:0] RST_CURRENT_HIGH = 10'd245;
  localparam logic [SampleWidth-1:0] RST_VOLTAGE_SP   = 10'd220;
  localparam logic [CountWidth-1:0]  RST_DWELL_LIMIT  = 12'd2000;
  localparam logic [CountWidth-1:0]  RST_RECOVER_LIM  = 12'd1000;
  localparam logic [DutyWidth-1:0]   RST_DUTY_CEILING = 8'd255;

  // Fixed thresholds of the control law.
  localparam logic [SampleWidth-1:0] CUR_DIV_ONE      = 10'd320;
  localparam logic [SampleWidth-1:0] CUR_DIV_TWO      = 10'd640;
  localparam logic [SampleWidth-1:0] CUR_DIV_THREE    = 10'd960;
  localparam logic [SampleWidth-1:0] BULK_RESET_LEVEL = 10'd234;
  localparam logic signed [11:0]     COMP_LOW_LEVEL   = 12'sd208;
  localparam logic signed [11:0]     COMP_CLEAR_LEVEL = 12'sd216;
  localparam logic [SampleWidth-1:0] VOLT_HIGH_LEVEL  = 10'd240;
  localparam logic [SampleWidth-1:0] VOLT_LOW_LEVEL   = 10'd170;
  localparam logic [DutyWidth-1:0]   DUTY_LOAD_HIGH   = 8'd160;
  localparam logic [DutyWidth-1:0]   DUTY_LOAD_LOW    = 8'd130;
  localparam logic [SampleWidth-1:0] TAPER_LOW_LEVEL  = 10'd10;
  localparam logic [SampleWidth-1:0] TAPER_HIGH_LEVEL = 10'd30;
  localparam logic [DutyWidth-1:0]   DUTY_STEP_UP     = 8'd3;

  typedef struct packed {
    logic [SampleWidth-1:0] current_low;
    logic [SampleWidth-1:0] current_high;
    logic [SampleWidth-1:0] voltage_sp;
    logic [CountWidth-1:0]  dwell_limit;
    logic [CountWidth-1:0]  recover_limit;
    logic [DutyWidth-1:0]   duty_ceiling;
  } cfg_t;

  typedef struct packed {
    mode_e                 mode;
    logic [DutyWidth-1:0]  duty;
    logic [CountWidth-1:0] bulk_cnt;
    logic                  bulk_reached;
    logic [CountWidth-1:0] over_cnt;
    logic [CountWidth-1:0] low_cnt;
    logic [CountWidth-1:0] taper_cnt;
  } state_t;

  function automatic logic [CountWidth-1:0] sat_inc(input logic [CountWidth-1:0] c);
    return (c == {CountWidth{1'b1}}) ? c : c + 1'b1;
  endfunction

  function automatic logic [ModeWidth-1:0] mode_code(input mode_e m);
    logic [ModeWidth-1:0] code;
    case (m)
      MODE_CV:      code = CODE_CV;
      MODE_TRICKLE: code = CODE_TRICKLE;
      default:      code = CODE_CC;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/cccv_cfg_regs.sv -----
`default_nettype none

module cccv_cfg_regs (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                we_i,
  input  wire logic [cccv_pkg::CfgIdxWidth-1:0]    idx_i,
  input  wire logic [cccv_pkg::CfgDataWidth-1:0]   wdata_i,
  output cccv_pkg::cfg_t                           cfg_o
);

  cccv_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (we_i) begin
      case (cccv_pkg::cfg_reg_e'(idx_i))
        cccv_pkg::REG_CURRENT_LOW:  cfg_d.current_low   = wdata_i[9:0];
        cccv_pkg::REG_CURRENT_HIGH: cfg_d.current_high  = wdata_i[9:0];
        cccv_pkg::REG_VOLTAGE_SP:   cfg_d.voltage_sp    = wdata_i[9:0];
        cccv_pkg::REG_DWELL_LIMIT:  cfg_d.dwell_limit   = wdata_i;
        cccv_pkg::REG_RECOVER_LIM:  cfg_d.recover_limit = wdata_i;
        cccv_pkg::REG_DUTY_CEILING: cfg_d.duty_ceiling  = wdata_i[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.current_low   <= cccv_pkg::RST_CURRENT_LOW;
      cfg_q.current_high  <= cccv_pkg::RST_CURRENT_HIGH;
      cfg_q.voltage_sp    <= cccv_pkg::RST_VOLTAGE_SP;
      cfg_q.dwell_limit   <= cccv_pkg::RST_DWELL_LIMIT;
      cfg_q.recover_limit <= cccv_pkg::RST_RECOVER_LIM;
      cfg_q.duty_ceiling  <= cccv_pkg::RST_DUTY_CEILING;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ----- rtl/cccv_step.sv -----
`default_nettype none

module cccv_step (
  input  wire cccv_pkg::cfg_t                      cfg_i,
  input  wire cccv_pkg::state_t                    state_i,
  input  wire logic [cccv_pkg::SampleWidth-1:0]    voltage_i,
  input  wire logic [cccv_pkg::SampleWidth-1:0]    current_i,
  output cccv_pkg::state_t                         state_o
);

  logic [1:0]                        cur_quot;
  logic signed [11:0]                comp;
  logic signed [11:0]                sp_s;
  logic                              comp_gt;
  logic                              comp_lt;
  logic [cccv_pkg::DutyWidth:0]      inc1_sum;
  logic [cccv_pkg::DutyWidth:0]      inc3_sum;
  logic [cccv_pkg::DutyWidth-1:0]    duty_up1;
  logic [cccv_pkg::DutyWidth-1:0]    duty_up3;
  logic [cccv_pkg::DutyWidth-1:0]    duty_dn;
  logic [cccv_pkg::DutyWidth-1:0]    duty_reg;
  logic [cccv_pkg::DutyWidth-1:0]    load_high;
  logic [cccv_pkg::DutyWidth-1:0]    load_low;
  logic                              back_to_cc;

  // The current term of the compensation is a quotient of at most three.
  always_comb begin
    if (current_i >= cccv_pkg::CUR_DIV_THREE) begin
      cur_quot = 2'd3;
    end else if (current_i >= cccv_pkg::CUR_DIV_TWO) begin
      cur_quot = 2'd2;
    end else if (current_i >= cccv_pkg::CUR_DIV_ONE) begin
      cur_quot = 2'd1;
    end else begin
      cur_quot = 2'd0;
    end
  end

  assign comp    = $signed({2'b00, voltage_i}) - $signed({10'd0, cur_quot});
  assign sp_s    = $signed({2'b00, cfg_i.voltage_sp});
  assign comp_gt = comp > sp_s;
  assign comp_lt = comp < sp_s;

  // Saturating duty arithmetic.
  assign inc1_sum  = {1'b0, state_i.duty} + 9'd1;
  assign inc3_sum  = {1'b0, state_i.duty} + {1'b0, cccv_pkg::DUTY_STEP_UP};
  assign duty_up1  = (inc1_sum > {1'b0, cfg_i.duty_ceiling}) ? cfg_i.duty_ceiling
                                                              : inc1_sum[7:0];
  assign duty_up3  = (inc3_sum > {1'b0, cfg_i.duty_ceiling}) ? cfg_i.duty_ceiling
                                                              : inc3_sum[7:0];
  assign duty_dn   = (state_i.duty == '0) ? state_i.duty : state_i.duty - 1'b1;
  assign duty_reg  = comp_gt ? duty_dn : (comp_lt ? duty_up3 : state_i.duty);
  assign load_high = (cccv_pkg::DUTY_LOAD_HIGH > cfg_i.duty_ceiling) ? cfg_i.duty_ceiling
                                                                     : cccv_pkg::DUTY_LOAD_HIGH;
  assign load_low  = (cccv_pkg::DUTY_LOAD_LOW > cfg_i.duty_ceiling) ? cfg_i.duty_ceiling
                                                                    : cccv_pkg::DUTY_LOAD_LOW;

  always_comb begin
    state_o    = state_i;
    back_to_cc = 1'b0;
    case (state_i.mode)
      cccv_pkg::MODE_CC: begin
        if (current_i < cfg_i.current_low) begin
          state_o.duty = duty_up1;
        end else if (current_i > cfg_i.current_high) begin
          state_o.duty = duty_dn;
        end
        if (current_i >= cfg_i.current_low) begin
          state_o.bulk_cnt = cccv_pkg::sat_inc(state_i.bulk_cnt);
          if (state_o.bulk_cnt > cfg_i.dwell_limit) begin
            state_o.bulk_reached = 1'b1;
          end
        end
        if ((current_i < cccv_pkg::BULK_RESET_LEVEL) && (current_i != '0)) begin
          state_o.bulk_cnt = '0;
        end
        if (state_o.bulk_reached) begin
          if (comp_gt) begin
            state_o.over_cnt = cccv_pkg::sat_inc(state_i.over_cnt);
          end
          if (comp_lt) begin
            state_o.over_cnt = '0;
          end
        end
        if (state_o.over_cnt >= cfg_i.dwell_limit) begin
          state_o.mode = cccv_pkg::MODE_CV;
        end
      end
      cccv_pkg::MODE_CV: begin
        state_o.duty = duty_reg;
        if (comp < cccv_pkg::COMP_LOW_LEVEL) begin
          state_o.low_cnt = cccv_pkg::sat_inc(state_i.low_cnt);
          back_to_cc      = state_o.low_cnt >= cfg_i.recover_limit;
        end
        if (comp > cccv_pkg::COMP_CLEAR_LEVEL) begin
          state_o.low_cnt = '0;
        end
        // Extreme raw voltage overrides the regulation step.
        if (voltage_i > cccv_pkg::VOLT_HIGH_LEVEL) begin
          state_o.duty = load_high;
        end
        if (voltage_i < cccv_pkg::VOLT_LOW_LEVEL) begin
          state_o.duty = load_low;
        end
        if (current_i < cccv_pkg::TAPER_LOW_LEVEL) begin
          state_o.taper_cnt = cccv_pkg::sat_inc(state_i.taper_cnt);
        end
        if (current_i > cccv_pkg::TAPER_HIGH_LEVEL) begin
          state_o.taper_cnt = '0;
        end
        // Taper completion wins over a return to constant current.
        if (state_o.taper_cnt >= cfg_i.dwell_limit) begin
          state_o.mode = cccv_pkg::MODE_TRICKLE;
        end else if (back_to_cc) begin
          state_o.mode = cccv_pkg::MODE_CC;
        end
      end
      cccv_pkg::MODE_TRICKLE: begin
        state_o.duty = duty_reg;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/cc_cv_trickle_charge_controller.sv -----
// Battery charge controller with constant current, constant voltage and
// trickle modes. Each transfer on the slave stream is one voltage/current
// sample pair of a control tick; each transfer on the master stream is the
// PWM duty and charge mode after that tick, one result per sample, in order.
// Thresholds, dwell limits and the duty ceiling are set through the plain
// write port (cfg_we_i, cfg_idx_i, cfg_wdata_i); the user must write them
// only while the block is idle, as the block itself does not enforce it.
// Indexes beyond the register list are ignored. A sample lands in an input
// register, and the control law, a single pass of compares and saturating
// counters, updates the state and loads the output register whenever the
// output is free. One sample per cycle is taken in sustained flow while the
// receiver keeps up; the control law works straight from the input register.
// When the receiver stalls, the output register holds its result and the
// input register still takes one more sample; s_axis_tready then drops
// until the output is taken. Reset clears both stream stages, loads the
// register defaults, and starts in constant current with zero duty and
// cleared counters.
`default_nettype none

module cc_cv_trickle_charge_controller (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // Fields from bit 0: voltage_sample [9:0], current_sample [19:10], zero fill.
  input  wire logic [23:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // Fields from bit 0: pwm_duty [7:0], charge_mode [9:8], zero fill.
  output logic [15:0]      m_axis_tdata,
  input  wire logic        cfg_we_i,
  input  wire logic [cccv_pkg::CfgIdxWidth-1:0]  cfg_idx_i,
  input  wire logic [cccv_pkg::CfgDataWidth-1:0] cfg_wdata_i
);

  cccv_pkg::cfg_t   cfg;
  cccv_pkg::state_t state_q, state_d;

  logic                               in_vld_q, in_vld_d;
  logic [cccv_pkg::SampleWidth-1:0]   volt_q;
  logic [cccv_pkg::SampleWidth-1:0]   curr_q;
  logic                               out_vld_q, out_vld_d;
  logic [cccv_pkg::DutyWidth-1:0]     duty_out_q;
  logic [cccv_pkg::ModeWidth-1:0]     mode_out_q;
  logic                               out_free;
  logic                               advance;
  logic                               in_xfer;

  cccv_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (cfg_we_i),
    .idx_i   (cfg_idx_i),
    .wdata_i (cfg_wdata_i),
    .cfg_o   (cfg)
  );

  cccv_step u_step (
    .cfg_i     (cfg),
    .state_i   (state_q),
    .voltage_i (volt_q),
    .current_i (curr_q),
    .state_o   (state_d)
  );

  assign out_free      = !out_vld_q || m_axis_tready;
  assign advance       = in_vld_q && out_free;
  assign s_axis_tready = !in_vld_q || out_free;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_xfer) begin
      in_vld_d = 1'b1;
    end else if (advance) begin
      in_vld_d = 1'b0;
    end
    out_vld_d = out_free ? in_vld_q : out_vld_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q               <= 1'b0;
      out_vld_q              <= 1'b0;
      state_q.mode           <= cccv_pkg::MODE_CC;
      state_q.duty           <= '0;
      state_q.bulk_cnt       <= '0;
      state_q.bulk_reached   <= 1'b0;
      state_q.over_cnt       <= '0;
      state_q.low_cnt        <= '0;
      state_q.taper_cnt      <= '0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
      if (advance) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      volt_q <= s_axis_tdata[9:0];
      curr_q <= s_axis_tdata[19:10];
    end
    if (advance) begin
      duty_out_q <= state_d.duty;
      mode_out_q <= cccv_pkg::mode_code(state_d.mode);
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {6'd0, mode_out_q, duty_out_q};

  // The mode register stays one-hot.
  assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot(state_q.mode))
    else $error("charger mode register is not one-hot");

  // Trickle is final until reset.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.mode == cccv_pkg::MODE_TRICKLE) |=> (state_q.mode == cccv_pkg::MODE_TRICKLE))
    else $error("charger left trickle mode");

  // The bulk flag is sticky.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !$fell(state_q.bulk_reached))
    else $error("bulk flag was cleared");

  // A sample waiting behind a stalled output stays in the input register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && !out_free) |=> (in_vld_q && $stable(volt_q) && $stable(curr_q)))
    else $error("pending sample lost during output stall");

  // The state changes only when an item moves to the output register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(state_q))
    else $error("controller state changed without a sample");

endmodule

`default_nettype wire
